// ===== design/fmms_pkg.sv =====
package fmms_pkg;

    localparam int PIXEL_W = 16;
    localparam int GRAY_W = 8;
    localparam int INDEX_W = 15;
    localparam int MAX_PIXELS_DEF = 32768;

    // The numerator is diff * 255, which fits in pixel width plus gray width.
    localparam int NUM_W = PIXEL_W + GRAY_W;
    // The span max - min + 1 can reach 65536, one bit wider than a pixel.
    localparam int SPAN_W = PIXEL_W + 1;

    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 16'hFFFF;
    localparam logic [GRAY_W-1:0] GRAY_MAX = 8'hFF;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [SPAN_W-1:0] span;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GRAY_W-1:0] quot;
        logic [SPAN_W-1:0] rem;
    } t_div_res;

endpackage

// ===== design/fmms_divider.sv =====
module fmms_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fmms_pkg::t_div_req i_req,
    output fmms_pkg::t_div_res o_res
);
    import fmms_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [SPAN_W-1:0] r_span;
    logic [SPAN_W-1:0] r_rem;
    logic [GRAY_W-1:0] r_quot;

    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   trial_sub;
    logic              ge;
    logic [SPAN_W-1:0] n_rem;

    // Restoring division: one numerator bit enters the partial remainder per cycle.
    always_comb begin
        trial     = {r_rem, r_num[NUM_W-1]};
        trial_sub = trial - {1'b0, r_span};
        ge        = (trial >= {1'b0, r_span});
        n_rem     = ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The quotient never exceeds eight bits since diff stays below the span.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.num;
            r_span <= i_req.span;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[GRAY_W-2:0], ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// ===== design/frame_min_max_stretch_to_8bit.sv =====
// Loads may be accepted back to back.
// A read with a valid index passes through S_READ, the bit-serial divider in S_DIV and
// then S_ROUND; a read at or beyond the pixel count goes straight to S_ROUND.
// A read holds off the next request until its result is registered, and longer while
// an earlier result waits on i_stall.
// Synchronous active-low reset clears count, min, max and frame state, not the store.
module frame_min_max_stretch_to_8bit #(
    parameter int MAX_PIXELS = fmms_pkg::MAX_PIXELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [fmms_pkg::PIXEL_W-1:0] i_pixel,
    input  logic                         i_frame_end,
    input  logic [fmms_pkg::INDEX_W-1:0] i_read_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [fmms_pkg::GRAY_W-1:0]  o_gray,
    output logic                         o_index_valid
);
    import fmms_pkg::*;

    localparam int CW    = $clog2(MAX_PIXELS + 1);
    localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DIV   = 4'b0100,
        S_ROUND = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic [PIXEL_W-1:0] r_min;
    logic [PIXEL_W-1:0] r_max;
    logic               r_closed;
    logic               r_idx_ok;
    logic               r_out_valid;
    logic [GRAY_W-1:0]  r_gray;
    logic               r_index_valid;
    logic [PIXEL_W-1:0] r_rd_data;
    logic [PIXEL_W-1:0] r_store [MAX_PIXELS];

    logic               accept;
    logic               is_load;
    logic               is_read;
    logic [CW-1:0]      eff_count;
    logic [PIXEL_W-1:0] eff_min;
    logic [PIXEL_W-1:0] eff_max;
    logic               load_wr;
    logic [CMP_W-1:0]   ridx_ext;
    logic               idx_ok;
    logic [PIXEL_W-1:0] diff;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W:0]    rem2;
    logic               round_up;
    logic [GRAY_W-1:0]  gray_rnd;
    logic               out_free;
    t_div_req           div_req;
    t_div_res           div_res;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign is_load = accept && (i_kind == KIND_LOAD);
    assign is_read = accept && (i_kind == KIND_READ);

    // The first load after a closed frame sees a fresh frame.
    assign eff_count = r_closed ? '0 : r_count;
    assign eff_min   = r_closed ? PIXEL_MAX : r_min;
    assign eff_max   = r_closed ? '0 : r_max;
    assign load_wr   = is_load && (eff_count < CW'(MAX_PIXELS));

    assign ridx_ext = CMP_W'(i_read_index);
    assign idx_ok   = (ridx_ext < CMP_W'(r_count));

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_store[eff_count[AW-1:0]] <= i_pixel;
        end
        if (is_read) begin
            r_rd_data <= r_store[ridx_ext[AW-1:0]];
        end
    end

    always_comb begin
        diff = (r_rd_data > r_min) ? (r_rd_data - r_min) : '0;
        if (r_max >= r_min) begin
            span = {1'b0, r_max} - {1'b0, r_min} + SPAN_W'(1);
        end else begin
            span = SPAN_W'(1);
        end
        div_req.start = (r_state == S_READ);
        div_req.num   = {diff, {GRAY_W{1'b0}}} - NUM_W'(diff);
        div_req.span  = span;
    end

    fmms_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    // Round half to even on the remainder left by the divider.
    always_comb begin
        rem2     = {div_res.rem, 1'b0};
        round_up = (rem2 > {1'b0, span}) ||
                   ((rem2 == {1'b0, span}) && div_res.quot[0]);
        gray_rnd = (round_up && (div_res.quot != GRAY_MAX)) ?
                   div_res.quot + GRAY_W'(1) : div_res.quot;
    end

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (is_read) begin
                    n_state = idx_ok ? S_READ : S_ROUND;
                end
            end
            S_READ: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min       <= PIXEL_MAX;
            r_max       <= '0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (is_load) begin
                r_closed <= i_frame_end;
                if (load_wr) begin
                    r_count <= eff_count + CW'(1);
                    r_min   <= (i_pixel < eff_min) ? i_pixel : eff_min;
                    r_max   <= (i_pixel > eff_max) ? i_pixel : eff_max;
                end else begin
                    r_count <= eff_count;
                    r_min   <= eff_min;
                    r_max   <= eff_max;
                end
            end
            if ((r_state == S_ROUND) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_idx_ok <= idx_ok;
        end
        if ((r_state == S_ROUND) && out_free) begin
            r_gray        <= r_idx_ok ? gray_rnd : '0;
            r_index_valid <= r_idx_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_gray        = r_gray;
    assign o_index_valid = r_index_valid;

endmodule

// ===== tb/fmms_checker.sv =====
`timescale 1ns / 100ps

module fmms_checker #(
    parameter int MAX_PIXELS = fmms_pkg::MAX_PIXELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_stall,
    input  logic                         i_kind,
    input  logic [fmms_pkg::PIXEL_W-1:0] i_pixel,
    input  logic                         i_frame_end,
    input  logic [fmms_pkg::INDEX_W-1:0] i_read_index,
    input  logic                         i_res_valid,
    input  logic                         i_res_stall,
    input  logic [fmms_pkg::GRAY_W-1:0]  i_gray,
    input  logic                         i_index_valid,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);
    import fmms_pkg::*;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              index_valid;
    } t_gray_result;

    logic [PIXEL_W-1:0] pixel_store [MAX_PIXELS];
    logic [PIXEL_W-1:0] lo_seen;
    logic [PIXEL_W-1:0] hi_seen;
    int                 held;
    logic               closed;
    t_gray_result       gray_queue [$];
    t_gray_result       want;
    int                 fail_count = 0;
    int                 checked = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = gray_queue.size();
    assign o_checked    = checked;

    // Stretch a stored pixel against the span of the current frame, rounding half to even.
    function automatic t_gray_result stretch_read(input int idx);
        t_gray_result res;
        int           pix;
        int           diff;
        int           span;
        int           num;
        int           quot;
        int           rem_part;
        res.gray        = '0;
        res.index_valid = 1'b0;
        if (idx < held && idx < MAX_PIXELS) begin
            pix      = pixel_store[idx];
            diff     = (pix > lo_seen) ? pix - lo_seen : 0;
            span     = (hi_seen >= lo_seen) ? hi_seen - lo_seen + 1 : 1;
            num      = diff * GRAY_MAX;
            quot     = num / span;
            rem_part = num % span;
            if (2 * rem_part > span || (2 * rem_part == span && quot % 2 == 1)) begin
                quot++;
            end
            if (quot > GRAY_MAX) begin
                quot = GRAY_MAX;
            end
            res.gray        = GRAY_W'(quot);
            res.index_valid = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held    = 0;
            lo_seen = PIXEL_MAX;
            hi_seen = '0;
            closed  = 1'b0;
            gray_queue.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (gray_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with no read waiting: gray %0d index_valid %0b",
                                 $realtime, i_gray, i_index_valid);
                    end
                end else begin
                    want = gray_queue.pop_front();
                    checked++;
                    if (i_gray !== want.gray || i_index_valid !== want.index_valid) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: gray %0d index_valid %0b, expected %0d %0b",
                                     $realtime, i_gray, i_index_valid, want.gray,
                                     want.index_valid);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_kind == KIND_LOAD) begin
                    // The first load after a closed frame opens a new one.
                    if (closed) begin
                        held    = 0;
                        lo_seen = PIXEL_MAX;
                        hi_seen = '0;
                        closed  = 1'b0;
                    end
                    if (held < MAX_PIXELS) begin
                        pixel_store[held] = i_pixel;
                        if (i_pixel < lo_seen) begin
                            lo_seen = i_pixel;
                        end
                        if (i_pixel > hi_seen) begin
                            hi_seen = i_pixel;
                        end
                        held++;
                    end
                    if (i_frame_end) begin
                        closed = 1'b1;
                    end
                end else begin
                    gray_queue.push_back(stretch_read(int'(i_read_index)));
                end
            end
        end
    end

endmodule

// ===== tb/frame_min_max_stretch_to_8bit_test.sv =====
`timescale 1ns / 100ps

module frame_min_max_stretch_to_8bit_test;
    import fmms_pkg::*;

    localparam int STORE_DEPTH    = MAX_PIXELS_DEF;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_kind = KIND_LOAD;
    logic [PIXEL_W-1:0] i_pixel = '0;
    logic               i_frame_end = 1'b0;
    logic [INDEX_W-1:0] i_read_index = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [GRAY_W-1:0]  o_gray;
    logic               o_index_valid;

    int fail_count;
    int pending_results;
    int results_checked;

    int loads_sent = 0;
    int reads_sent = 0;
    int stim_held = 0;
    bit stim_closed = 1'b0;
    bit no_gaps = 1'b0;
    int idle_cycles = 0;
    int stall_left = 0;
    int quiet_left = 0;
    int stall_roll;

    frame_min_max_stretch_to_8bit #(
        .MAX_PIXELS(STORE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_pixel      (i_pixel),
        .i_frame_end  (i_frame_end),
        .i_read_index (i_read_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_gray       (o_gray),
        .o_index_valid(o_index_valid)
    );

    fmms_checker #(
        .MAX_PIXELS(STORE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_kind       (i_kind),
        .i_pixel      (i_pixel),
        .i_frame_end  (i_frame_end),
        .i_read_index (i_read_index),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_gray       (o_gray),
        .i_index_valid(o_index_valid),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (results_checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel(input int mode, input int base);
        int roll;
        case (mode)
            1: return PIXEL_W'(base + $urandom_range(0, 15));
            2: return PIXEL_W'(base);
            3: begin
                roll = $urandom_range(0, 2);
                if (roll == 0) begin
                    return '0;
                end
                if (roll == 1) begin
                    return PIXEL_MAX;
                end
                return PIXEL_W'($urandom);
            end
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic kind, input logic [PIXEL_W-1:0] pixel,
                                input logic frame_end, input logic [INDEX_W-1:0] idx);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind       <= kind;
        i_pixel      <= pixel;
        i_frame_end  <= frame_end;
        i_read_index <= idx;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic load_pixel(input logic [PIXEL_W-1:0] pixel, input logic frame_end);
        send_request(KIND_LOAD, pixel, frame_end, INDEX_W'($urandom));
        if (stim_closed) begin
            stim_held   = 0;
            stim_closed = 1'b0;
        end
        if (stim_held < STORE_DEPTH) begin
            stim_held++;
        end
        if (frame_end) begin
            stim_closed = 1'b1;
        end
        loads_sent++;
    endtask

    task automatic read_pixel(input int idx);
        send_request(KIND_READ, PIXEL_W'($urandom), 1'($urandom), INDEX_W'(idx));
        reads_sent++;
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
    endtask

    // Output side: random stalls, mostly short, with quiet stretches in between.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (quiet_left > 0) begin
            i_stall <= 1'b0;
            quiet_left--;
        end else begin
            i_stall <= 1'b0;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 2) begin
                quiet_left = $urandom_range(50, 200);
            end else if (stall_roll < 25) begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL frame_min_max_stretch_to_8bit");
            $finish;
        end
    end

    initial begin
        int start_items;
        int mode;
        int base;
        int len;
        int roll;
        bit open_ended;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reads before anything is loaded are out of range.
        read_pixel(0);
        read_pixel(32767);
        // Single pixel frame still open, then a span of six with a tie that rounds to even.
        load_pixel(16'd0, 1'b0);
        read_pixel(0);
        load_pixel(16'd5, 1'b0);
        load_pixel(16'd1, 1'b1);
        read_pixel(2);
        read_pixel(1);
        read_pixel(3);
        // Full 16-bit span; the first load also opens a new frame.
        load_pixel(16'd0, 1'b0);
        load_pixel(PIXEL_MAX, 1'b0);
        load_pixel(16'd1, 1'b1);
        read_pixel(0);
        read_pixel(1);
        read_pixel(2);
        read_pixel(3);
        load_pixel(PIXEL_MAX, 1'b1);
        read_pixel(0);
        read_pixel(1);
        wait_for_drain();

        start_items = loads_sent + reads_sent;
        while (loads_sent + reads_sent < start_items + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                wait_for_drain();
            end
            no_gaps    = ($urandom_range(0, 3) == 0);
            mode       = $urandom_range(0, 3);
            base       = $urandom_range(0, 65520);
            open_ended = ($urandom_range(0, 9) == 0);
            roll       = $urandom_range(0, 99);
            if (roll < 10) begin
                len = 1;
            end else if (roll < 75) begin
                len = $urandom_range(2, 24);
            end else if (roll < 95) begin
                len = $urandom_range(25, 120);
            end else begin
                len = $urandom_range(200, 600);
            end
            for (int n = 0; n < len; n++) begin
                load_pixel(pick_pixel(mode, base), n == len - 1 && !open_ended);
                if ($urandom_range(0, 7) == 0) begin
                    read_pixel($urandom_range(0, stim_held));
                end
            end
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 9) < 8) begin
                    read_pixel($urandom_range(0, stim_held - 1));
                end else begin
                    read_pixel($urandom_range(0, 32767));
                end
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d loads and %0d reads over random frames, open and closed.",
                 loads_sent, reads_sent);
        $display("Checked %0d gray results against the predicted stretch.", results_checked);
        if (fail_count == 0) begin
            $display("PASS frame_min_max_stretch_to_8bit");
        end else begin
            $display("FAIL frame_min_max_stretch_to_8bit");
        end
        $finish;
    end

endmodule

// ===== frame_min_max_stretch_to_8bit.f =====
design/fmms_pkg.sv
design/fmms_divider.sv
design/frame_min_max_stretch_to_8bit.sv
tb/fmms_checker.sv
tb/frame_min_max_stretch_to_8bit_test.sv
